@@ rtl/d8_upstream_watershed_unit_macros.svh @@
// ----------------------------------------------------------------------------
// d8 upstream watershed unit: assertion macros
// Shared concurrent assertion forms clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef D8_UPSTREAM_WATERSHED_UNIT_MACROS_SVH
`define D8_UPSTREAM_WATERSHED_UNIT_MACROS_SVH

// property must hold at every clock edge out of reset
`define D8UW_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("d8uw: assertion failed");

// condition must never be seen at a clock edge out of reset
`define D8UW_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("d8uw: forbidden condition seen");

`endif

@@ rtl/d8uw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d8uw_pkg
// Types, codes and neighbor tables of the D8 upstream watershed unit.
// ----------------------------------------------------------------------------
package d8uw_pkg;

	localparam int MAX_SIDE  = 256;
	localparam int MAX_CELLS = 65536;
	localparam int CELL_W    = 16;
	localparam int SIDE_W    = 9;
	localparam int COORD_W   = 8;
	localparam int CODE_W    = 8;
	localparam int COUNT_W   = 17;
	localparam int EPOCH_W   = 4;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_RUN    = 2'd1,
		KIND_READ   = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	localparam logic CFG_GRID_WIDTH  = 1'b0;
	localparam logic CFG_GRID_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_POUR,
		ST_DEQ,
		ST_QWAIT,
		ST_NB,
		ST_DONE
	} state_t;

	// neighbor order E, SE, S, SW, W, NW, N, NE (bit k = neighbor k)
	localparam logic [7:0] NB_XP = 8'b1000_0011;
	localparam logic [7:0] NB_XM = 8'b0011_1000;
	localparam logic [7:0] NB_YP = 8'b0000_1110;
	localparam logic [7:0] NB_YM = 8'b1110_0000;
	localparam logic [CODE_W-1:0] NB_CODE [8] = '{
		8'd16, 8'd32, 8'd64, 8'd128, 8'd1, 8'd2, 8'd4, 8'd8
	};

	typedef struct packed {
		logic               valid;
		logic [CELL_W-1:0]  index;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [CODE_W-1:0]  code;
	} nbr_t;

endpackage

@@ rtl/d8_upstream_watershed_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d8_upstream_watershed_unit
// Upstream watershed of a pour cell on a D8 flow-direction raster.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): kind, cell_index, dir_code. Load stores
// a code, run delineates the watershed of a pour cell, read returns one mask
// bit. Every transaction gives exactly one result on the output channel
// (out_valid/out_ready), held in an output register until taken; the next
// input is taken in the cycle that register is emptied.
// Config channel (cfg_valid/cfg_ready) is always ready; index 0 sets the
// grid width, index 1 the height. Write it only while the unit is idle.
// Load and out-of-grid results are registered on acceptance; a read first passes
// the tag-memory read and the READ state. A run divides the pour index by the
// width serially, seeds the queue, handles each marked cell (queue read, base
// multiply, eight pipelined direction-memory reads on one port, a flush), then
// finds the queue empty and posts the result. Cells are walked breadth first.
// The mask store keeps a 4-bit run tag per cell. After reset, and once every
// 15 runs, a clearing pass sweeps all 65536 tag entries; in_ready is low
// meanwhile. A stalled output blocks new input only, never config.
// ----------------------------------------------------------------------------
module d8_upstream_watershed_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic [d8uw_pkg::CELL_W-1:0]   cell_index,
	input  logic [d8uw_pkg::CODE_W-1:0]   dir_code,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          mask_bit,
	output logic [d8uw_pkg::COUNT_W-1:0]  marked_count,
	output logic                          status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [d8uw_pkg::SIDE_W-1:0]   cfg_data
);

	localparam int CW = d8uw_pkg::CELL_W;
	localparam int RW = d8uw_pkg::COORD_W;
	localparam int EW = d8uw_pkg::EPOCH_W;

	d8uw_pkg::state_t state_q, state_nxt;

	logic [d8uw_pkg::SIDE_W-1:0] w_q, h_q, ew, eh;
	logic [2*d8uw_pkg::SIDE_W-1:0] cells;
	logic in_grid, accept;

	logic [CW-1:0] clr_cnt_q;
	logic          clr_run_q;
	logic [EW-1:0] epoch_q;
	logic [CW-1:0] idx_q, rem_q, base_q;
	logic [RW-1:0] row_q, col_q;
	logic [CW:0]   head_q, tail_q;
	logic [d8uw_pkg::COUNT_W-1:0] marked_q;
	logic [3:0]    k_q;

	logic          chk_vld_s1;
	logic [7:0]    chk_code_s1;
	logic [CW-1:0] chk_idx_s1;
	logic [RW-1:0] chk_row_s1, chk_col_s1;

	logic out_valid_q, mask_q, status_q;
	logic [d8uw_pkg::COUNT_W-1:0] count_q;

	d8uw_pkg::nbr_t nb;

	// memories
	logic [7:0]      dir_mem [d8uw_pkg::MAX_CELLS];
	logic [EW-1:0]   tag_mem [d8uw_pkg::MAX_CELLS];
	logic [CW-1:0]   q_mem   [d8uw_pkg::MAX_CELLS];
	logic [7:0]      dir_rd;
	logic [EW-1:0]   tag_rd;
	logic [CW-1:0]   q_rd;

	logic          dir_we, tag_we, q_we, push;
	logic [CW-1:0] dir_waddr, tag_waddr, q_waddr;
	logic [7:0]    dir_wdata;
	logic [EW-1:0] tag_wdata;
	logic [CW-1:0] q_wdata;

	always_comb begin
		if (w_q == '0) begin
			ew = 9'd1;
		end else if (w_q > 9'(d8uw_pkg::MAX_SIDE)) begin
			ew = 9'(d8uw_pkg::MAX_SIDE);
		end else begin
			ew = w_q;
		end
		if (h_q == '0) begin
			eh = 9'd1;
		end else if (h_q > 9'(d8uw_pkg::MAX_SIDE)) begin
			eh = 9'(d8uw_pkg::MAX_SIDE);
		end else begin
			eh = h_q;
		end
	end

	assign cells   = ew * eh;
	assign in_grid = {2'b00, cell_index} < cells;
	assign in_ready = (state_q == d8uw_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign accept  = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	d8uw_nbr u_nbr (
		.row    (row_q),
		.col    (col_q),
		.base   (base_q),
		.k      (k_q[2:0]),
		.width  (ew),
		.height (eh),
		.nbr    (nb)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			d8uw_pkg::ST_CLR: begin
				if (clr_cnt_q == '1) begin
					state_nxt = clr_run_q ? d8uw_pkg::ST_DIV : d8uw_pkg::ST_IDLE;
				end
			end
			d8uw_pkg::ST_IDLE: begin
				if (accept && in_grid && kind == d8uw_pkg::KIND_RUN) begin
					state_nxt = (epoch_q == '1) ? d8uw_pkg::ST_CLR : d8uw_pkg::ST_DIV;
				end else if (accept && in_grid && kind == d8uw_pkg::KIND_READ) begin
					state_nxt = d8uw_pkg::ST_READ;
				end
			end
			d8uw_pkg::ST_READ:  state_nxt = d8uw_pkg::ST_IDLE;
			d8uw_pkg::ST_DIV: begin
				if (rem_q < {7'd0, ew}) begin
					state_nxt = d8uw_pkg::ST_POUR;
				end
			end
			d8uw_pkg::ST_POUR:  state_nxt = d8uw_pkg::ST_DEQ;
			d8uw_pkg::ST_DEQ: begin
				state_nxt = (head_q == tail_q) ? d8uw_pkg::ST_DONE : d8uw_pkg::ST_QWAIT;
			end
			d8uw_pkg::ST_QWAIT: state_nxt = d8uw_pkg::ST_NB;
			d8uw_pkg::ST_NB: begin
				if (k_q == 4'd8) begin
					state_nxt = d8uw_pkg::ST_DEQ;
				end
			end
			d8uw_pkg::ST_DONE:  state_nxt = d8uw_pkg::ST_IDLE;
			default:            state_nxt = d8uw_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		push = (state_q == d8uw_pkg::ST_NB) && chk_vld_s1 && (dir_rd == chk_code_s1);

		dir_we = (state_q == d8uw_pkg::ST_POUR)
			|| (accept && in_grid && kind == d8uw_pkg::KIND_LOAD);
		dir_waddr = (state_q == d8uw_pkg::ST_POUR) ? idx_q : cell_index;
		dir_wdata = (state_q == d8uw_pkg::ST_POUR) ? 8'd0 : dir_code;

		tag_we = (state_q == d8uw_pkg::ST_CLR) || (state_q == d8uw_pkg::ST_POUR) || push;
		case (state_q)
			d8uw_pkg::ST_CLR:  tag_waddr = clr_cnt_q;
			d8uw_pkg::ST_POUR: tag_waddr = idx_q;
			default:           tag_waddr = chk_idx_s1;
		endcase
		tag_wdata = (state_q == d8uw_pkg::ST_CLR) ? '0 : epoch_q;

		q_we = (state_q == d8uw_pkg::ST_POUR) || push;
		q_waddr = (state_q == d8uw_pkg::ST_POUR) ? '0 : tail_q[CW-1:0];
		q_wdata = (state_q == d8uw_pkg::ST_POUR) ? {row_q, rem_q[RW-1:0]}
			: {chk_row_s1, chk_col_s1};
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
		dir_rd <= dir_mem[nb.index];
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_waddr] <= tag_wdata;
		end
		tag_rd <= tag_mem[cell_index];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_waddr] <= q_wdata;
		end
		q_rd <= q_mem[head_q[CW-1:0]];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= 9'(d8uw_pkg::MAX_SIDE);
			h_q <= 9'(d8uw_pkg::MAX_SIDE);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == d8uw_pkg::CFG_GRID_WIDTH) begin
				w_q <= cfg_data;
			end else begin
				h_q <= cfg_data;
			end
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= d8uw_pkg::ST_CLR;
			clr_cnt_q  <= '0;
			clr_run_q  <= 1'b0;
			epoch_q    <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			marked_q   <= '0;
			k_q        <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				d8uw_pkg::ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1 && clr_run_q) begin
						epoch_q <= EW'(1);
					end
				end
				d8uw_pkg::ST_IDLE: begin
					if (accept && in_grid && kind == d8uw_pkg::KIND_RUN) begin
						clr_run_q <= (epoch_q == '1);
						if (epoch_q != '1) begin
							epoch_q <= epoch_q + 1'b1;
						end
					end
				end
				d8uw_pkg::ST_POUR: begin
					head_q   <= '0;
					tail_q   <= (CW+1)'(1);
					marked_q <= 17'd1;
				end
				d8uw_pkg::ST_DEQ: begin
					if (head_q != tail_q) begin
						head_q <= head_q + 1'b1;
					end
				end
				d8uw_pkg::ST_QWAIT: begin
					k_q        <= '0;
					chk_vld_s1 <= 1'b0;
				end
				d8uw_pkg::ST_NB: begin
					k_q        <= k_q + 1'b1;
					chk_vld_s1 <= (k_q != 4'd8) && nb.valid;
					if (push) begin
						tail_q   <= tail_q + 1'b1;
						marked_q <= marked_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers of the walk
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= cell_index;
			rem_q <= cell_index;
			row_q <= '0;
		end
		if (state_q == d8uw_pkg::ST_DIV && rem_q >= {7'd0, ew}) begin
			rem_q <= rem_q - {7'd0, ew};
			row_q <= row_q + 1'b1;
		end
		if (state_q == d8uw_pkg::ST_QWAIT) begin
			row_q  <= q_rd[2*RW-1:RW];
			col_q  <= q_rd[RW-1:0];
			base_q <= CW'(q_rd[2*RW-1:RW] * ew) + {8'd0, q_rd[RW-1:0]};
		end
		if (state_q == d8uw_pkg::ST_NB) begin
			chk_code_s1 <= nb.code;
			chk_idx_s1  <= nb.index;
			chk_row_s1  <= nb.row;
			chk_col_s1  <= nb.col;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == d8uw_pkg::ST_READ || state_q == d8uw_pkg::ST_DONE) begin
			out_valid_q <= 1'b1;
		end else if (accept && !(in_grid && (kind == d8uw_pkg::KIND_RUN
				|| kind == d8uw_pkg::KIND_READ))) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == d8uw_pkg::ST_READ) begin
			mask_q   <= (tag_rd == epoch_q) && (epoch_q != '0);
			status_q <= 1'b0;
			count_q  <= marked_q;
		end else if (state_q == d8uw_pkg::ST_DONE) begin
			mask_q   <= 1'b0;
			status_q <= 1'b0;
			count_q  <= marked_q;
		end else if (accept) begin
			mask_q   <= 1'b0;
			status_q <= (kind != d8uw_pkg::KIND_UNUSED) && !in_grid;
			count_q  <= marked_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign mask_bit     = mask_q;
	assign marked_count = count_q;
	assign status       = status_q;

`include "d8_upstream_watershed_unit_macros.svh"

	`D8UW_ASSERT(a_ready_only_idle, in_ready |-> (state_q == d8uw_pkg::ST_IDLE))
	`D8UW_ASSERT(a_queue_order, head_q <= tail_q)
	`D8UW_ASSERT(a_done_gives_result, (state_q == d8uw_pkg::ST_DONE) |=> out_valid)
	`D8UW_NEVER(a_push_only_in_walk, push && (state_q != d8uw_pkg::ST_NB))

endmodule

@@ rtl/d8uw_nbr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d8uw_nbr
// Neighbor k of the current cell: grid bounds check, linear index, the
// neighbor's coordinates and the code that points back at the cell.
// ----------------------------------------------------------------------------
module d8uw_nbr (
	input  logic [d8uw_pkg::COORD_W-1:0] row,
	input  logic [d8uw_pkg::COORD_W-1:0] col,
	input  logic [d8uw_pkg::CELL_W-1:0]  base,
	input  logic [2:0]                   k,
	input  logic [d8uw_pkg::SIDE_W-1:0]  width,
	input  logic [d8uw_pkg::SIDE_W-1:0]  height,
	output d8uw_pkg::nbr_t               nbr
);

	logic                        xp, xm, yp, ym;
	logic [d8uw_pkg::SIDE_W-1:0] col_inc, row_inc;
	logic [d8uw_pkg::CELL_W:0]   sum;

	always_comb begin
		xp = d8uw_pkg::NB_XP[k];
		xm = d8uw_pkg::NB_XM[k];
		yp = d8uw_pkg::NB_YP[k];
		ym = d8uw_pkg::NB_YM[k];
		col_inc = {1'b0, col} + 9'd1;
		row_inc = {1'b0, row} + 9'd1;
		nbr.valid = !(xp && col_inc >= width) && !(xm && col == '0)
			&& !(yp && row_inc >= height) && !(ym && row == '0);
		sum = {1'b0, base};
		if (yp) begin
			sum = sum + {8'd0, width};
		end else if (ym) begin
			sum = sum - {8'd0, width};
		end
		if (xp) begin
			sum = sum + 17'd1;
		end else if (xm) begin
			sum = sum - 17'd1;
		end
		nbr.index = sum[d8uw_pkg::CELL_W-1:0];
		nbr.row = yp ? row + 8'd1 : (ym ? row - 8'd1 : row);
		nbr.col = xp ? col + 8'd1 : (xm ? col - 8'd1 : col);
		nbr.code = d8uw_pkg::NB_CODE[k];
	end

endmodule
